### hw/rtl/llnf_pkg.sv
// Shared types and constants for the light level noise filter.
package llnf_pkg;

  // Field widths
  localparam int LIGHT_W    = 20;  // Q16.4 light value
  localparam int FACTOR_W   = 17;  // Q1.16 smoothing weight
  localparam int FRAC_W     = 16;  // extra fraction bits of the smoothed level
  localparam int AVG_W      = LIGHT_W + FRAC_W;  // Q16.20 average and level
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Quotient bits resolved by one divider cell
  localparam int DIV_STEPS  = 4;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(65536);

  // Register reset values
  localparam logic [LIGHT_W-1:0]  SPIKE_TH_RST  = LIGHT_W'(1600);
  localparam logic [LIGHT_W-1:0]  CHANGE_TH_RST = LIGHT_W'(80);
  localparam logic [FACTOR_W-1:0] NORMAL_F_RST  = FACTOR_W'(328);
  localparam logic [FACTOR_W-1:0] FAST_F_RST    = FACTOR_W'(32768);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIKE_TH  = 2'd0,
    CFG_CHANGE_TH = 2'd1,
    CFG_NORMAL_F  = 2'd2,
    CFG_FAST_F    = 2'd3
  } cfg_reg_t;

  // Per-item side data that travels along the pipeline
  typedef struct packed {
    logic               valid;
    logic [LIGHT_W-1:0] used;
    logic               rejected;
  } tag_t;

endpackage

### hw/rtl/llnf_ring.sv
// Sample ring as a shift line of taps, spike rejection and running sum.
module llnf_ring
  import llnf_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int SUM_W = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               adv,
  input  logic [LIGHT_W-1:0] sample,
  input  logic [LIGHT_W-1:0] spike_th,
  output tag_t               tag_out,
  output logic [SUM_W-1:0]   sum_out
);

  logic [LIGHT_W-1:0] taps [DEPTH];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [LIGHT_W-1:0] oldest;
  logic [LIGHT_W-1:0] rise;
  logic               spike;
  logic [LIGHT_W-1:0] used;

  // Oldest entry sits at the tail of the line
  assign oldest = taps[DEPTH-1];
  assign rise   = sample - oldest;
  assign spike  = (sample > oldest) && (rise > spike_th);
  assign used   = spike ? oldest : sample;

  assign sum_next = sum + SUM_W'(used) - SUM_W'(oldest);

  // Taps shift by one on every item; the new value enters at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps[i] <= '0;
      end
      sum <= '0;
    end else if (accept) begin
      taps[0] <= used;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
      sum <= sum_next;
    end
  end

  // Stage register toward the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out.valid    <= accept;
      tag_out.used     <= used;
      tag_out.rejected <= spike;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_out <= sum_next;
    end
  end

endmodule

### hw/rtl/llnf_div_cell.sv
// One cell of the constant divider: resolves a few quotient bits per stage.
module llnf_div_cell
  import llnf_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  tag_t                                 tag_in,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rem_in,
  input  logic [AVG_W-1:0]                     word_in,
  output tag_t                                 tag_out,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rem_out,
  output logic [AVG_W-1:0]                     word_out
);

  localparam int REM_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(DEPTH);

  logic [REM_W-1:0] rem_c  [DIV_STEPS+1];
  logic [AVG_W-1:0] word_c [DIV_STEPS+1];
  logic [REM_W:0]   trial  [DIV_STEPS];

  // Restoring division: dividend bits leave the top of the word,
  // quotient bits enter at the bottom
  always_comb begin
    rem_c[0]  = rem_in;
    word_c[0] = word_in;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_c[k], word_c[k][AVG_W-1]};
      if (trial[k] >= DIVISOR) begin
        rem_c[k+1]  = REM_W'(trial[k] - DIVISOR);
        word_c[k+1] = {word_c[k][AVG_W-2:0], 1'b1};
      end else begin
        rem_c[k+1]  = trial[k][REM_W-1:0];
        word_c[k+1] = {word_c[k][AVG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= rem_c[DIV_STEPS];
      word_out <= word_c[DIV_STEPS];
    end
  end

endmodule

### hw/rtl/llnf_ema.sv
// Adaptive exponential smoothing of the level toward the average; result register.
module llnf_ema
  import llnf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  tag_t                tag_in,
  input  logic [AVG_W-1:0]    avg,
  input  logic [LIGHT_W-1:0]  change_th,
  input  logic [FACTOR_W-1:0] normal_f,
  input  logic [FACTOR_W-1:0] fast_f,
  output logic                result_valid,
  output logic [LIGHT_W-1:0]  smoothed_level,
  output logic                spike_rejected
);

  localparam int PROD_W = AVG_W + FACTOR_W + 2;

  logic [AVG_W-1:0]         level;
  logic [AVG_W-1:0]         level_next;
  logic [AVG_W-1:0]         used_ext;
  logic [AVG_W-1:0]         gap;
  logic                     fast;
  logic [FACTOR_W-1:0]      f_raw;
  logic [FACTOR_W-1:0]      f;
  logic signed [FACTOR_W:0] f_s;
  logic signed [AVG_W:0]    delta;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] level_wide;

  // Factor choice from the distance between used sample and current level
  assign used_ext = {tag_in.used, {FRAC_W{1'b0}}};
  assign gap      = (used_ext >= level) ? (used_ext - level) : (level - used_ext);
  assign fast     = gap > {change_th, {FRAC_W{1'b0}}};
  assign f_raw    = fast ? fast_f : normal_f;
  assign f        = (f_raw > FACTOR_ONE) ? FACTOR_ONE : f_raw;
  assign f_s      = {1'b0, f};

  // level + floor(f * (avg - level) / 2^16)
  assign delta      = $signed({1'b0, avg}) - $signed({1'b0, level});
  assign prod       = delta * f_s;
  assign level_wide = $signed({{(PROD_W - AVG_W){1'b0}}, level}) + (prod >>> FRAC_W);
  assign level_next = level_wide[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= tag_in.valid;
      if (tag_in.valid) begin
        level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag_in.valid) begin
      spike_rejected <= tag_in.rejected;
    end
  end

  assign smoothed_level = level[AVG_W-1:FRAC_W];

endmodule

### hw/rtl/light_level_noise_filter_unit.sv
// Light level noise filter top: ring, divider cell chain, smoothing stage, config.
// Path of a sample: ring stage, AVG_W/DIV_STEPS divider cells (9 with the default
// widths), smoothing stage; each of these stages is registered.
// Throughput: one item per cycle unless a held result stalls; the smoothing update (one
// multiply against the previous level) and the ring's running sum are feedback loops.
// Reset (rst, synchronous): ring taps, running sum and smoothed level cleared,
// pipeline emptied, registers loaded with their reset values.
module light_level_noise_filter_unit
  import llnf_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [LIGHT_W-1:0]    sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [LIGHT_W-1:0]    smoothed_level,
  output logic                  spike_rejected,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int REM_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = LIGHT_W + REM_W;
  localparam int NCELL  = AVG_W / DIV_STEPS;

  logic [LIGHT_W-1:0]  spike_th;
  logic [LIGHT_W-1:0]  change_th;
  logic [FACTOR_W-1:0] normal_f;
  logic [FACTOR_W-1:0] fast_f;

  logic             adv;
  logic             accept;
  logic [SUM_W-1:0] sum0;
  tag_t             tag_chain  [NCELL+1];
  logic [REM_W-1:0] rem_chain  [NCELL+1];
  logic [AVG_W-1:0] word_chain [NCELL+1];

  // Pipeline moves unless a finished item is held at the output
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;
  assign cfg_ready    = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spike_th  <= SPIKE_TH_RST;
      change_th <= CHANGE_TH_RST;
      normal_f  <= NORMAL_F_RST;
      fast_f    <= FAST_F_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SPIKE_TH:  spike_th  <= cfg_data[LIGHT_W-1:0];
        CFG_CHANGE_TH: change_th <= cfg_data[LIGHT_W-1:0];
        CFG_NORMAL_F:  normal_f  <= cfg_data[FACTOR_W-1:0];
        CFG_FAST_F:    fast_f    <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  llnf_ring #(
    .DEPTH (RING_DEPTH),
    .SUM_W (SUM_W)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .adv      (adv),
    .sample   (sample),
    .spike_th (spike_th),
    .tag_out  (tag_chain[0]),
    .sum_out  (sum0)
  );

  // Dividend is sum * 2^16; the high part of the sum is already below the depth
  assign rem_chain[0]  = sum0[SUM_W-1:LIGHT_W];
  assign word_chain[0] = {sum0[LIGHT_W-1:0], {FRAC_W{1'b0}}};

  for (genvar c = 0; c < NCELL; c++) begin : g_div
    llnf_div_cell #(
      .DEPTH (RING_DEPTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .tag_in   (tag_chain[c]),
      .rem_in   (rem_chain[c]),
      .word_in  (word_chain[c]),
      .tag_out  (tag_chain[c+1]),
      .rem_out  (rem_chain[c+1]),
      .word_out (word_chain[c+1])
    );
  end

  llnf_ema u_ema (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .tag_in         (tag_chain[NCELL]),
    .avg            (word_chain[NCELL]),
    .change_th      (change_th),
    .normal_f       (normal_f),
    .fast_f         (fast_f),
    .result_valid   (result_valid),
    .smoothed_level (smoothed_level),
    .spike_rejected (spike_rejected)
  );

  // Reset leaves the ring stage and the result register empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !tag_chain[0].valid))
    else $error("pipeline not empty after reset");

  // An accepted item enters the ring stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> tag_chain[0].valid)
    else $error("accepted item lost at ring stage");

  // An item leaving the divider chain becomes a result
  a_chain_to_result: assert property (@(posedge clk) disable iff (rst)
    (adv && tag_chain[NCELL].valid) |=> result_valid)
    else $error("item lost between divider and result");

  // A held result keeps the pipeline frozen; checked at the last divider cell's tag
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(tag_chain[NCELL]))
    else $error("divider chain moved while result held");

endmodule
